FILE: hdl/gcfsf_pkg.sv
package gcfsf_pkg;

  // grid size per axis
  localparam int unsigned LON_CELLS  = 64;
  localparam int unsigned LAT_CELLS  = 32;
  localparam int unsigned TIME_CELLS = 8;
  localparam int unsigned VEL_CELLS  = 32;

  localparam int unsigned DATA_W = 24;
  localparam int unsigned CFG_AW = 3;

  localparam longint unsigned CELL_COUNT =
    64'(LON_CELLS) * 64'(LAT_CELLS) * 64'(TIME_CELLS) * 64'(VEL_CELLS);
  localparam int unsigned CELL_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  // bitmap rows
  localparam int unsigned ROW_BITS = 64;
  localparam int unsigned BIT_W    = $clog2(ROW_BITS);
  localparam int unsigned ROWS     = int'((CELL_COUNT + ROW_BITS - 1) / ROW_BITS);
  localparam int unsigned ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  // cell address accumulator and shared multiplier widths
  localparam int unsigned ACC_W  = (CELL_W > BIT_W + 1) ? CELL_W : BIT_W + 1;
  localparam int unsigned MUL_W  = (ACC_W > DATA_W) ? ACC_W : DATA_W;
  localparam int unsigned PROD_W = MUL_W + DATA_W;

  // register map
  localparam logic [CFG_AW-1:0] REG_LON_RECIP  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_LAT_RECIP  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_VEL_RECIP  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_TIME_RECIP = 3'd3;
  localparam logic [CFG_AW-1:0] REG_LAT_BIAS   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_TIME_BIAS  = 3'd5;

  // axes in cell address order, outermost first
  typedef enum logic [1:0] {
    AX_VEL,
    AX_TIME,
    AX_LON,
    AX_LAT
  } axis_t;

  function automatic logic [DATA_W-1:0] cells_of(input axis_t ax);
    logic [DATA_W-1:0] n;
    case (ax)
      AX_VEL:  n = DATA_W'(VEL_CELLS);
      AX_TIME: n = DATA_W'(TIME_CELLS);
      AX_LON:  n = DATA_W'(LON_CELLS);
      AX_LAT:  n = DATA_W'(LAT_CELLS);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

FILE: hdl/grid_cell_first_sample_filter.sv
// First-sample-per-cell filter over a 4-D grid (speed, time, longitudinal,
// lateral). Each request carries one sample point in Q8; speed, rel_time +
// time_bias, pos_x and pos_y + lat_bias are each multiplied by their Q16
// reciprocal step register and truncated to a cell index. Points with a
// negative operand or an index past the grid are dropped. A point whose cell
// is not yet marked in the visited bitmap comes out unchanged and the cell is
// marked; later points in that cell are dropped. One 24x24 multiplier is
// shared for both the quantizing and the cell address fold (multiply, range
// check, scale and add per axis). in_stall stays high until a point is done,
// so no new point is taken before then; a kept point also waits on a stalled
// output register, and points dropped for sign or range free the input
// earlier. The bitmap is a 64-bit-wide RAM of 8192 rows, cleared one row per
// cycle with in_stall high after reset and for a request with batch_start
// set, before the point is handled. Configuration writes are taken at any
// time but must only be issued while the block is idle.
module grid_cell_first_sample_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [gcfsf_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [gcfsf_pkg::DATA_W-1:0]    cfg_wdata,
  // sample requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_batch_start,
  input  logic signed [gcfsf_pkg::DATA_W-1:0] in_pos_x,
  input  logic signed [gcfsf_pkg::DATA_W-1:0] in_pos_y,
  input  logic signed [gcfsf_pkg::DATA_W-1:0] in_speed,
  input  logic signed [gcfsf_pkg::DATA_W-1:0] in_rel_time,
  input  logic signed [gcfsf_pkg::DATA_W-1:0] in_station,
  input  logic signed [gcfsf_pkg::DATA_W-1:0] in_offset_d,
  // kept points
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [gcfsf_pkg::DATA_W-1:0] out_kept_x,
  output logic signed [gcfsf_pkg::DATA_W-1:0] out_kept_y,
  output logic signed [gcfsf_pkg::DATA_W-1:0] out_kept_speed,
  output logic signed [gcfsf_pkg::DATA_W-1:0] out_kept_time,
  output logic signed [gcfsf_pkg::DATA_W-1:0] out_kept_station,
  output logic signed [gcfsf_pkg::DATA_W-1:0] out_kept_offset
);

  localparam int unsigned DW = gcfsf_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_CLEAR,  // sweep bitmap rows to zero
    ST_IDLE,   // wait for a request
    ST_MUL,    // operand x reciprocal
    ST_CHK,    // range check, latch index
    ST_SCL,    // address accumulator x cells of this axis
    ST_ADD,    // accumulator += index
    ST_RD,     // bitmap row read
    ST_TEST    // test bit, mark and emit
  } state_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [DW-1:0]        lon_recip_r, lat_recip_r, vel_recip_r, time_recip_r;
  logic signed [DW-1:0] lat_bias_r, time_bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_recip_r  <= DW'(65536);
      lat_recip_r  <= DW'(655360);
      vel_recip_r  <= DW'(262144);
      time_recip_r <= DW'(65536);
      lat_bias_r   <= DW'(1206);
      time_bias_r  <= -DW'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        gcfsf_pkg::REG_LON_RECIP:  lon_recip_r  <= cfg_wdata;
        gcfsf_pkg::REG_LAT_RECIP:  lat_recip_r  <= cfg_wdata;
        gcfsf_pkg::REG_VEL_RECIP:  vel_recip_r  <= cfg_wdata;
        gcfsf_pkg::REG_TIME_RECIP: time_recip_r <= cfg_wdata;
        gcfsf_pkg::REG_LAT_BIAS:   lat_bias_r   <= cfg_wdata;
        gcfsf_pkg::REG_TIME_BIAS:  time_bias_r  <= cfg_wdata;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // sequencer state and datapath registers
  // ---------------------------------------------------------------------
  state_t                            state_r, state_nxt;
  gcfsf_pkg::axis_t                  ax_r, ax_nxt;
  logic                              pend_r, pend_nxt;   // item waits behind a clear
  logic [gcfsf_pkg::ROW_AW-1:0]      clr_r, clr_nxt;
  logic [gcfsf_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic [gcfsf_pkg::ACC_W-1:0]       acc_r, acc_nxt;
  logic [DW-1:0]                     q_r, q_nxt;
  logic                              out_valid_r, out_valid_nxt;

  // per-axis operands, time and lateral biased, 25 bit signed
  logic signed [DW:0]                opnd_r [4];
  logic [DW-1:0]                     px_r, py_r, sp_r, rt_r, st_r, od_r;
  logic [DW-1:0]                     kx_r, ky_r, ks_r, kt_r, kst_r, kod_r;

  // bitmap RAM
  logic [gcfsf_pkg::ROW_BITS-1:0]    mem [gcfsf_pkg::ROWS];
  logic [gcfsf_pkg::ROW_BITS-1:0]    rdata_r;
  logic [gcfsf_pkg::ROW_AW-1:0]      rd_row;
  logic [gcfsf_pkg::BIT_W-1:0]       rd_bit;
  logic                              mem_we;
  logic [gcfsf_pkg::ROW_AW-1:0]      mem_waddr;
  logic [gcfsf_pkg::ROW_BITS-1:0]    mem_wdata;

  logic                              in_acc;
  logic                              out_free;
  logic                              emit;
  logic signed [DW:0]                cur_op;
  logic [DW-1:0]                     cur_recip;
  logic [gcfsf_pkg::MUL_W-1:0]       mul_a;
  logic [DW-1:0]                     mul_b;
  logic [DW-1:0]                     quot;
  logic [gcfsf_pkg::ACC_W-1:0]       row_shift;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  assign row_shift = acc_r >> gcfsf_pkg::BIT_W;
  assign rd_row    = row_shift[gcfsf_pkg::ROW_AW-1:0];
  assign rd_bit    = acc_r[gcfsf_pkg::BIT_W-1:0];

  assign cur_op = opnd_r[ax_r];
  always_comb begin
    case (ax_r)
      gcfsf_pkg::AX_VEL:  cur_recip = vel_recip_r;
      gcfsf_pkg::AX_TIME: cur_recip = time_recip_r;
      gcfsf_pkg::AX_LON:  cur_recip = lon_recip_r;
      gcfsf_pkg::AX_LAT:  cur_recip = lat_recip_r;
      default:            cur_recip = '0;
    endcase
  end

  // shared multiplier: quantize in ST_MUL, scale address in ST_SCL
  always_comb begin
    if (state_r == ST_SCL) begin
      mul_a = gcfsf_pkg::MUL_W'(acc_r);
      mul_b = gcfsf_pkg::cells_of(ax_r);
    end else begin
      mul_a = gcfsf_pkg::MUL_W'(cur_op[DW-1:0]);
      mul_b = cur_recip;
    end
  end

  // Q8 x Q16 -> drop 24 fraction bits
  assign quot = prod_r[2*DW-1:DW];

  // found a fresh cell and the output register can take it
  assign emit = (state_r == ST_TEST) && !rdata_r[rd_bit] && out_free;

  // ---------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    pend_nxt      = pend_r;
    clr_nxt       = clr_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    q_nxt         = q_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == gcfsf_pkg::ROW_AW'(gcfsf_pkg::ROWS - 1)) begin
          clr_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? ST_MUL : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          ax_nxt  = gcfsf_pkg::AX_VEL;
          acc_nxt = '0;
          if (in_batch_start) begin
            pend_nxt  = 1'b1;
            clr_nxt   = '0;
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (cur_op[DW]) begin
          state_nxt = ST_IDLE;  // negative operand: drop
        end else begin
          prod_nxt  = mul_a * mul_b;
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (quot >= gcfsf_pkg::cells_of(ax_r)) begin
          state_nxt = ST_IDLE;  // outside grid: drop
        end else begin
          q_nxt     = quot;
          state_nxt = ST_SCL;
        end
      end
      ST_SCL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        acc_nxt = prod_r[gcfsf_pkg::ACC_W-1:0] + gcfsf_pkg::ACC_W'(q_r);
        if (ax_r == gcfsf_pkg::AX_LAT) begin
          state_nxt = ST_RD;
        end else begin
          ax_nxt    = gcfsf_pkg::axis_t'(ax_r + 2'd1);
          state_nxt = ST_MUL;
        end
      end
      ST_RD: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (rdata_r[rd_bit]) begin
          state_nxt = ST_IDLE;  // cell already taken
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ax_r        <= gcfsf_pkg::AX_VEL;
      pend_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      pend_r      <= pend_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    if (in_acc) begin
      opnd_r[gcfsf_pkg::AX_VEL]  <= {in_speed[DW-1], in_speed};
      opnd_r[gcfsf_pkg::AX_TIME] <= {in_rel_time[DW-1], in_rel_time}
                                    + {time_bias_r[DW-1], time_bias_r};
      opnd_r[gcfsf_pkg::AX_LON]  <= {in_pos_x[DW-1], in_pos_x};
      opnd_r[gcfsf_pkg::AX_LAT]  <= {in_pos_y[DW-1], in_pos_y}
                                    + {lat_bias_r[DW-1], lat_bias_r};
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      sp_r <= in_speed;
      rt_r <= in_rel_time;
      st_r <= in_station;
      od_r <= in_offset_d;
    end
    if (emit) begin
      kx_r  <= px_r;
      ky_r  <= py_r;
      ks_r  <= sp_r;
      kt_r  <= rt_r;
      kst_r <= st_r;
      kod_r <= od_r;
    end
  end

  // ---------------------------------------------------------------------
  // visited bitmap: one write port (clear sweep or mark), one read port
  // ---------------------------------------------------------------------
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = emit;
      mem_waddr = rd_row;
      mem_wdata = rdata_r | (gcfsf_pkg::ROW_BITS'(1) << rd_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[rd_row];
  end

  assign out_kept_x       = kx_r;
  assign out_kept_y       = ky_r;
  assign out_kept_speed   = ks_r;
  assign out_kept_time    = kt_r;
  assign out_kept_station = kst_r;
  assign out_kept_offset  = kod_r;

endmodule
